### design/crsa_pkg.sv
// ----------------------------------------------------------------------------
// crsa_pkg
// shared types and codes for the contiguous ring span allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crsa_pkg;

   localparam int CMD_W  = 3;
   localparam int LEN_W  = 17;
   localparam int OFF_W  = 16;
   localparam int STAT_W = 3;
   localparam int ARITH_W = 18;

   localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_REFUSED   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_type;

endpackage

`default_nettype wire

### design/crsa_controller.sv
// ----------------------------------------------------------------------------
// crsa_controller
// sequences one word at a time: capture, execute, hold the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crsa_controller
   import crsa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output ctrl_type      ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         ST_EXEC: begin
            ctrl.execute = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/crsa_datapath.sv
// ----------------------------------------------------------------------------
// crsa_datapath
// offset, wrap mark and in-use count registers with the command arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crsa_datapath
   import crsa_pkg::*;
#(
   parameter int MAX_BYTES = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_type           ctrl,
   input  wire logic               csr_write_enable,
   input  wire logic [LEN_W-1:0]   csr_write_data,
   input  wire logic [CMD_W-1:0]   req_command,
   input  wire logic [LEN_W-1:0]   req_length,
   output logic                    rsp_ok,
   output logic [OFF_W-1:0]        rsp_span_offset,
   output logic [LEN_W-1:0]        rsp_span_length,
   output logic [STAT_W-1:0]       rsp_status
);

   localparam int LEN_MAX = (1 << LEN_W) - 1;
   localparam int CLAMP   = (MAX_BYTES < LEN_MAX) ? MAX_BYTES : LEN_MAX;
   localparam int SW      = $clog2(CLAMP + 1);
   localparam int RST_BS  = (MAX_BYTES < 65536) ? MAX_BYTES : 65536;
   localparam logic [ARITH_W-1:0] CLAMP_A = ARITH_W'(CLAMP);
   localparam logic [ARITH_W-1:0] MIN_A   = ARITH_W'(2);

   logic [SW-1:0]      bs_ff, wo_ff, ro_ff, wm_ff, used_ff;
   logic [SW-1:0]      wo_in, ro_in, wm_in, used_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [LEN_W-1:0]   len_ff;
   logic               ok_ff, ok_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [LEN_W-1:0]   slen_ff, slen_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;

   logic [ARITH_W-1:0] bs, wo, ro, wm, used, n;
   logic [ARITH_W-1:0] cfg_v, used_sum, wo_sum, bs_m1;
   logic [ARITH_W-1:0] ro_g, wm_g, avail, cap, glen, ro_next;
   logic               refuse, fits, wrapped;

   assign bs    = ARITH_W'(bs_ff);
   assign wo    = ARITH_W'(wo_ff);
   assign ro    = ARITH_W'(ro_ff);
   assign wm    = ARITH_W'(wm_ff);
   assign used  = ARITH_W'(used_ff);
   assign n     = ARITH_W'(len_ff);
   assign bs_m1 = bs - ARITH_W'(1);

   // config value clamped into range
   always_comb begin
      cfg_v = ARITH_W'(csr_write_data);
      if (cfg_v < MIN_A) cfg_v = MIN_A;
      if (cfg_v > CLAMP_A) cfg_v = CLAMP_A;
   end

   assign used_sum = used + n;
   assign refuse   = used_sum > bs;
   assign wo_sum   = wo + n;
   assign fits     = wo_sum <= bs_m1;

   // get span: wrap the read side first, then cap by count, request and room to the wrap mark
   assign wrapped = ro >= wm;
   assign ro_g    = wrapped ? '0 : ro;
   assign wm_g    = wrapped ? bs_m1 : wm;
   assign avail   = wm_g - ro_g;
   assign cap     = (used > n) ? n : used;
   assign glen    = (avail >= cap) ? cap : avail;
   assign ro_next = ro_g + glen;

   always_comb begin
      wo_in   = wo_ff;
      ro_in   = ro_ff;
      wm_in   = wm_ff;
      used_in = used_ff;
      ok_in   = 1'b0;
      off_in  = '0;
      slen_in = '0;
      stat_in = STAT_OK;
      case (cmd_ff)
         CMD_RESERVE: begin
            if (refuse) begin
               stat_in = STAT_REFUSED;
            end else if (fits) begin
               ok_in  = 1'b1;
               off_in = wo[OFF_W-1:0];
               wo_in  = wo_sum[SW-1:0];
            end else begin
               ok_in = 1'b1;
               wm_in = wo_ff;
               wo_in = n[SW-1:0];
            end
         end
         CMD_COMMIT: begin
            if (refuse) begin
               used_in = bs_ff;
               stat_in = STAT_OVERFLOW;
            end else begin
               used_in = used_sum[SW-1:0];
               ok_in   = 1'b1;
            end
         end
         CMD_RELEASE: begin
            if (n > used) begin
               used_in = '0;
               stat_in = STAT_UNDERFLOW;
            end else begin
               used_in = used_ff - n[SW-1:0];
               ok_in   = 1'b1;
            end
         end
         CMD_GET: begin
            wm_in = wm_g[SW-1:0];
            if (used_ff == '0) begin
               ro_in   = ro_g[SW-1:0];
               stat_in = STAT_EMPTY;
            end else begin
               ro_in   = ro_next[SW-1:0];
               ok_in   = 1'b1;
               off_in  = ro_g[OFF_W-1:0];
               slen_in = glen[LEN_W-1:0];
            end
         end
         CMD_CLEAR: begin
            wo_in   = '0;
            ro_in   = '0;
            wm_in   = bs_m1[SW-1:0];
            used_in = '0;
            ok_in   = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff   <= SW'(RST_BS);
         wo_ff   <= '0;
         ro_ff   <= '0;
         wm_ff   <= SW'(RST_BS - 1);
         used_ff <= '0;
      end else if (csr_write_enable) begin
         bs_ff   <= cfg_v[SW-1:0];
         wo_ff   <= '0;
         ro_ff   <= '0;
         wm_ff   <= cfg_v[SW-1:0] - SW'(1);
         used_ff <= '0;
      end else if (ctrl.execute) begin
         wo_ff   <= wo_in;
         ro_ff   <= ro_in;
         wm_ff   <= wm_in;
         used_ff <= used_in;
      end
   end

   // request and result words
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_command;
         len_ff <= req_length;
      end
      if (ctrl.execute) begin
         ok_ff   <= ok_in;
         off_ff  <= off_in;
         slen_ff <= slen_in;
         stat_ff <= stat_in;
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_span_offset = off_ff;
   assign rsp_span_length = slen_ff;
   assign rsp_status      = stat_ff;

endmodule

`default_nettype wire

### design/contiguous_ring_span_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_ring_span_allocator
// book-keeping for a byte ring that hands out contiguous spans only
// ----------------------------------------------------------------------------
// result word: request captured in idle, computed in exec, held in resp until taken
// a new request word is taken only after the previous result word is accepted on rsp_ready
// the three-state controller handles one word at a time
// reset: synchronous, offsets and count to zero, ring size to its default
`timescale 1ns / 1ps
`default_nettype none

module contiguous_ring_span_allocator
   import crsa_pkg::*;
#(
   parameter int MAX_BYTES = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [LEN_W-1:0]   csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CMD_W-1:0]   req_command,
   input  wire logic [LEN_W-1:0]   req_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ok,
   output logic [OFF_W-1:0]        rsp_span_offset,
   output logic [LEN_W-1:0]        rsp_span_length,
   output logic [STAT_W-1:0]       rsp_status
);

   ctrl_type ctrl;

   crsa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   crsa_datapath #(
      .MAX_BYTES (MAX_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_length       (req_length),
      .rsp_ok           (rsp_ok),
      .rsp_span_offset  (rsp_span_offset),
      .rsp_span_length  (rsp_span_length),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

### design/crsa_checker.sv
// ----------------------------------------------------------------------------
// crsa_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crsa_checker
   import crsa_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_ok,
   input wire logic [OFF_W-1:0]   rsp_span_offset,
   input wire logic [LEN_W-1:0]   rsp_span_length,
   input wire logic [STAT_W-1:0]  rsp_status
);

   // one word in flight
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while result pending");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##1 rsp_valid)
      else $error("result word not produced on time");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_span_offset) && $stable(rsp_span_length)
         && $stable(rsp_status))
      else $error("stalled result word changed");

   // failed words carry no span
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> rsp_span_offset == '0 && rsp_span_length == '0)
      else $error("failed word with nonzero span");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> rsp_status == STAT_OK)
      else $error("successful word with error status");

endmodule

bind contiguous_ring_span_allocator crsa_checker u_crsa_checker (.*);

`default_nettype wire

### tb/contiguous_ring_span_allocator_tb.sv
// ----------------------------------------------------------------------------
// contiguous_ring_span_allocator_tb
// Self-checking bench for the span allocator. A short directed run covers
// each command: refused and wrapping reserves, commit overflow, release
// underflow, empty and zero-length gets, wrap of the read offset and the
// unused command codes. Random words follow over a series of ring sizes,
// out-of-range sizes among them. Most of them are reserve, commit, get and
// release sequences; the rest is noise. Both handshakes idle in random
// bursts. A tracker class predicts every result word and compares each
// field as the word arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contiguous_ring_span_allocator_tb;
   import crsa_pkg::*;

   localparam int RING_MAX = 65536;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 88;
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;

   typedef struct packed {
      logic              ok;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [STAT_W-1:0] status;
   } span_result_type;

   class ring_tracker;
      logic [ARITH_W-1:0] ring_size;
      logic [ARITH_W-1:0] wr_ofs;
      logic [ARITH_W-1:0] rd_ofs;
      logic [ARITH_W-1:0] wrap_at;
      logic [ARITH_W-1:0] in_use;
      span_result_type pending_spans[$];
      span_result_type last_prediction;
      int errors;
      int results_checked;

      function void clear_ring();
         wr_ofs = '0;
         rd_ofs = '0;
         wrap_at = ring_size - ARITH_W'(1);
         in_use = '0;
      endfunction

      function void set_ring_size(logic [LEN_W-1:0] v);
         if (v < 2) ring_size = ARITH_W'(2);
         else if (v > RING_MAX) ring_size = ARITH_W'(RING_MAX);
         else ring_size = ARITH_W'(v);
         clear_ring();
      endfunction

      function span_result_type predict_span(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len);
         span_result_type r;
         logic [ARITH_W-1:0] n;
         logic [ARITH_W-1:0] avail;
         logic [ARITH_W-1:0] cap;
         logic [ARITH_W-1:0] take;
         r = '0;
         n = ARITH_W'(len);
         case (cmd)
            CMD_RESERVE: begin
               if (in_use + n > ring_size) begin
                  r.status = STAT_REFUSED;
               end else begin
                  r.ok = 1'b1;
                  if (wr_ofs + n <= ring_size - ARITH_W'(1)) begin
                     r.offset = wr_ofs[OFF_W-1:0];
                     wr_ofs = wr_ofs + n;
                  end else begin
                     wrap_at = wr_ofs;
                     wr_ofs = n;
                  end
               end
            end
            CMD_COMMIT: begin
               if (in_use + n > ring_size) begin
                  in_use = ring_size;
                  r.status = STAT_OVERFLOW;
               end else begin
                  in_use = in_use + n;
                  r.ok = 1'b1;
               end
            end
            CMD_RELEASE: begin
               if (n > in_use) begin
                  in_use = '0;
                  r.status = STAT_UNDERFLOW;
               end else begin
                  in_use = in_use - n;
                  r.ok = 1'b1;
               end
            end
            CMD_GET: begin
               if (rd_ofs >= wrap_at) begin
                  rd_ofs = '0;
                  wrap_at = ring_size - ARITH_W'(1);
               end
               if (in_use == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  avail = wrap_at - rd_ofs;
                  cap = (in_use > n) ? n : in_use;
                  take = (avail >= cap) ? cap : avail;
                  r.ok = 1'b1;
                  r.offset = rd_ofs[OFF_W-1:0];
                  r.length = take[LEN_W-1:0];
                  rd_ofs = rd_ofs + take;
               end
            end
            CMD_CLEAR: begin
               clear_ring();
               r.ok = 1'b1;
            end
            default: r = '0;
         endcase
         return r;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len);
         last_prediction = predict_span(cmd, len);
         pending_spans.push_back(last_prediction);
      endfunction

      function void check_result(span_result_type got);
         span_result_type want;
         if (pending_spans.size() == 0) begin
            $error("result word with no request outstanding");
            errors++;
            return;
         end
         want = pending_spans.pop_front();
         results_checked++;
         if (got.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok);
            errors++;
         end
         if (got.offset !== want.offset) begin
            $error("span_offset: expected %0d, actual %0d", want.offset, got.offset);
            errors++;
         end
         if (got.length !== want.length) begin
            $error("span_length: expected %0d, actual %0d", want.length, got.length);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [LEN_W-1:0] csr_write_data;
   logic req_valid;
   logic req_ready;
   logic [CMD_W-1:0] req_command;
   logic [LEN_W-1:0] req_length;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_ok;
   logic [OFF_W-1:0] rsp_span_offset;
   logic [LEN_W-1:0] rsp_span_length;
   logic [STAT_W-1:0] rsp_status;

   ring_tracker tracker;
   bit sender_gaps;
   bit receiver_stalls;
   int words_sent;
   int useful_words;
   int cycle_count;

   contiguous_ring_span_allocator #(
      .MAX_BYTES(RING_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_length(req_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_span_offset(rsp_span_offset),
      .rsp_span_length(rsp_span_length),
      .rsp_status(rsp_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin : result_monitor
      span_result_type seen;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         seen.ok = rsp_ok;
         seen.offset = rsp_span_offset;
         seen.length = rsp_span_length;
         seen.status = rsp_status;
         tracker.check_result(seen);
      end
   end

   // result side back-pressure
   initial begin
      rsp_ready <= 1'b0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len);
      int gap;
      gap = 0;
      if (sender_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_length <= len;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_request(cmd, len);
      words_sent++;
      if (cmd <= CMD_CLEAR) useful_words++;
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_spans.size() != 0);
   endtask

   task automatic write_ring_size(input logic [LEN_W-1:0] v);
      hold_until_drained();
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_ring_size(v);
   endtask

   function automatic logic [LEN_W-1:0] pick_length(logic [ARITH_W-1:0] size);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return LEN_W'($urandom_range(0, 17'h1FFFF));
      if (sel == 2) return LEN_W'(size + 1 - $urandom_range(0, 3));
      return LEN_W'($urandom_range(1, size / 4 + 1));
   endfunction

   task automatic run_random(input int quota);
      int start;
      int n;
      int taken;
      bit paused;
      logic [ARITH_W-1:0] size;
      start = useful_words;
      paused = 1'b0;
      size = tracker.ring_size;
      while (useful_words - start < quota) begin
         if (!paused && useful_words - start >= quota / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            // reserve, commit, read back and free
            n = $urandom_range(1, size / 3 + 1);
            taken = 0;
            send_word(CMD_RESERVE, LEN_W'(n));
            if ($urandom_range(0, 7) != 0) send_word(CMD_COMMIT, LEN_W'(n));
            repeat ($urandom_range(1, 3)) begin
               send_word(CMD_GET, $urandom_range(0, 1) ? LEN_W'(n) : pick_length(size));
               taken += tracker.last_prediction.length;
            end
            if ($urandom_range(0, 3) != 0) send_word(CMD_RELEASE, LEN_W'(taken));
            else send_word(CMD_RELEASE, pick_length(size));
         end else begin
            send_word(CMD_W'($urandom_range(0, CMD_SPARE_LAST)), pick_length(size));
         end
      end
   endtask

   initial begin
      logic [LEN_W-1:0] ring_plan [10];
      tracker = new();
      tracker.set_ring_size(LEN_W'(RING_MAX));
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_command <= CMD_RESERVE;
      req_length <= '0;
      ring_plan = '{17'd0, 17'd1, 17'd3, 17'd16, 17'd100, 17'h1FFFF, 17'd65535,
                    17'd1000, 17'd2, 17'd65536};
      ring_plan[7] = LEN_W'($urandom_range(3, 4096));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default ring size: empty get, refusals, saturation, wrap of the read side
      send_word(CMD_GET, 17'd5);
      send_word(CMD_RESERVE, 17'h1FFFF);
      send_word(CMD_RESERVE, 17'd0);
      send_word(CMD_RESERVE, 17'd65535);
      send_word(CMD_COMMIT, 17'd65536);
      send_word(CMD_COMMIT, 17'd1);
      send_word(CMD_GET, 17'h1FFFF);
      send_word(CMD_GET, 17'd10);
      send_word(CMD_GET, 17'd0);
      send_word(CMD_RELEASE, 17'h1FFFF);
      send_word(CMD_GET, 17'd3);
      send_word(CMD_SPARE_FIRST, 17'h1FFFF);
      send_word(CMD_SPARE_FIRST + 3'd1, 17'd7);
      send_word(CMD_SPARE_LAST, 17'd0);
      send_word(CMD_CLEAR, 17'h10000);

      // small ring: reserve that wraps to zero and get that follows the wrap mark
      write_ring_size(17'd10);
      send_word(CMD_RESERVE, 17'd6);
      send_word(CMD_COMMIT, 17'd6);
      send_word(CMD_GET, 17'd6);
      send_word(CMD_RELEASE, 17'd6);
      send_word(CMD_RESERVE, 17'd4);
      send_word(CMD_COMMIT, 17'd4);
      send_word(CMD_GET, 17'd100);
      send_word(CMD_RELEASE, 17'd5);

      for (int p = 0; p < 10; p++) begin
         write_ring_size(ring_plan[p]);
         sender_gaps = (p % 3 != 1) && (p != 9);
         receiver_stalls = (p % 3 != 2) && (p != 9);
         run_random(PHASE_WORDS);
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      $display("%0d request words sent, %0d result words checked", words_sent,
               tracker.results_checked);
      $display("ring sizes from 2 to 65536 bytes, register writes below and above range");
      if (tracker.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
